// ===== design/bdq_pkg.sv =====
package bdq_pkg;

   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_POP_FRONT  = 4'd2;
   localparam logic [3:0] OP_POP_BACK   = 4'd3;
   localparam logic [3:0] OP_SEARCH     = 4'd4;
   localparam logic [3:0] OP_REMOVE     = 4'd5;
   localparam logic [3:0] OP_HEAD       = 4'd6;
   localparam logic [3:0] OP_TAIL       = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        found;
      logic [1:0]  status;
      logic [4:0]  count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEADTAIL,
      ST_SCAN,
      ST_SHIFT
   } state_type;

endpackage

// ===== design/bounded_deque_with_search.sv =====
// push, pop, clear and no-op items answer in the cycle after acceptance, one item per cycle
// head and tail reads pass through the HEADTAIL state and a registered memory read, busy for one cycle
// search walks the stored entries one memory read per cycle and stops at the first match
// remove walks to the match, then moves each later entry down one per cycle
// reset clears the head index, the entry count and the controller; the entry memory is not cleared
// the receiver cannot stall: each result is shown for one cycle with rsp_valid
module bounded_deque_with_search #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bdq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output bdq_pkg::rsp_item_type rsp_item
);
   import bdq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;

   logic [DATA_W+31:0] req_val_ext;
   logic [DATA_W-1:0]  req_val;
   logic [DATA_W+31:0] rd_val_ext;
   logic [CW+4:0]      count_ext;
   logic [AW-1:0]      ptr_inc, ptr_inc2, head_inc, head_dec;
   logic [SW-1:0]      back_sum, tail_sum, back_wrap, tail_wrap;
   logic [AW-1:0]      back_pos, tail_pos;
   logic [CW-1:0]      k_next;
   logic               is_full, is_empty, match, scan_last, shift_done;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + AW'(1);
      end
      return r;
   endfunction

   assign req_val_ext = {{DATA_W{1'b0}}, req_item.value};
   assign req_val     = req_val_ext[DATA_W-1:0];
   assign rd_val_ext  = {32'd0, rd_data_ff};

   assign ptr_inc  = wrap_inc(ptr_ff);
   assign ptr_inc2 = wrap_inc(ptr_inc);
   assign head_inc = wrap_inc(head_ff);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   assign back_sum  = SW'(head_ff) + SW'(count_ff);
   assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
   assign back_pos  = back_wrap[AW-1:0];
   assign tail_sum  = back_sum - SW'(1);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign tail_pos  = tail_wrap[AW-1:0];

   assign k_next     = k_ff + CW'(1);
   assign is_full    = (count_ff >= CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign match      = (rd_data_ff == val_ff);
   assign scan_last  = (k_next == count_ff);
   assign shift_done = (k_next >= count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.opcode)
                  OP_HEAD, OP_TAIL: begin
                     if (!is_empty) state_in = ST_HEADTAIL;
                  end
                  OP_SEARCH, OP_REMOVE: begin
                     if (!is_empty) state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HEADTAIL: state_in = ST_IDLE;
         ST_SCAN: begin
            if (match) begin
               state_in = rem_ff ? ST_SHIFT : ST_IDLE;
            end else if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (shift_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = rd_data_ff;
      rd_addr      = ptr_inc;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in       = req_val;
               rem_in       = (req_item.opcode == OP_REMOVE);
               ptr_in       = head_ff;
               k_in         = '0;
               rd_addr      = head_ff;
               rsp_valid_in = 1'b1;
               case (req_item.opcode)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        wr_data  = req_val;
                        head_in  = head_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_pos;
                        wr_data  = req_val;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_SEARCH, OP_REMOVE: begin
                     rsp_valid_in = is_empty;
                  end
                  OP_HEAD: begin
                     if (is_empty) rsp_in.status = STATUS_EMPTY;
                     rsp_valid_in = is_empty;
                  end
                  OP_TAIL: begin
                     rd_addr = tail_pos;
                     if (is_empty) rsp_in.status = STATUS_EMPTY;
                     rsp_valid_in = is_empty;
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: rsp_in.status = STATUS_OK;
               endcase
            end
         end
         ST_HEADTAIL: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_value = rd_val_ext[31:0];
         end
         ST_SCAN: begin
            if (match) begin
               if (!rem_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.found = 1'b1;
               end
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
            end else begin
               ptr_in = ptr_inc;
               k_in   = k_next;
            end
         end
         ST_SHIFT: begin
            if (shift_done) begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_in.found = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data_ff;
               rd_addr = ptr_inc2;
               ptr_in  = ptr_inc;
               k_in    = k_next;
            end
         end
         default: rsp_valid_in = 1'b0;
      endcase
      count_ext    = {5'd0, count_in};
      rsp_in.count = count_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      k_ff   <= k_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bdq_pkg::*;

   localparam int DEQUE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_TAIL = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_item = '0;
   logic rsp_valid;
   rsp_item_type rsp_item;

   bounded_deque_with_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // deque shadow state
   logic [31:0] dq_store [DEQUE_DEPTH];
   logic [3:0]  dq_head = '0;
   logic [4:0]  dq_count = '0;

   req_item_type pend_items [$];
   int           pend_gaps [$];
   rsp_item_type expected_rsp [$];
   rsp_item_type want;
   int           gap_left = 0;
   int           fail_count = 0;

   function automatic logic [3:0] ring_idx(int offset);
      return dq_head + offset[3:0];
   endfunction

   function automatic rsp_item_type deque_apply(req_item_type req);
      rsp_item_type r;
      int k;
      int hit;
      r = '0;
      hit = -1;
      case (req.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (dq_count == DEQUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (req.opcode == OP_PUSH_FRONT) begin
                  dq_head = dq_head - 4'd1;
                  dq_store[dq_head] = req.value;
               end else begin
                  dq_store[ring_idx(dq_count)] = req.value;
               end
               dq_count = dq_count + 5'd1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (dq_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               if (req.opcode == OP_POP_FRONT) dq_head = dq_head + 4'd1;
               dq_count = dq_count - 5'd1;
            end
         end
         OP_SEARCH, OP_REMOVE: begin
            for (k = 0; k < dq_count; k++)
               if (hit < 0 && dq_store[ring_idx(k)] == req.value) hit = k;
            r.found = (hit >= 0);
            if (req.opcode == OP_REMOVE && hit >= 0) begin
               for (k = hit; k + 1 < dq_count; k++)
                  dq_store[ring_idx(k)] = dq_store[ring_idx(k + 1)];
               dq_count = dq_count - 5'd1;
            end
         end
         OP_HEAD, OP_TAIL: begin
            if (dq_count == 0) r.status = STATUS_EMPTY;
            else if (req.opcode == OP_HEAD) r.result_value = dq_store[dq_head];
            else r.result_value = dq_store[ring_idx(dq_count - 1)];
         end
         OP_CLEAR: begin
            dq_count = '0;
            dq_head = '0;
         end
         default: begin
         end
      endcase
      r.count = dq_count;
      return r;
   endfunction

   task automatic queue_item(logic [3:0] op, logic [31:0] val, int gap);
      req_item_type it;
      it.opcode = op;
      it.value = val;
      pend_items.push_back(it);
      pend_gaps.push_back(gap);
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return $urandom_range(0, 7);
      else if (sel < 55) return 32'h0;
      else if (sel < 60) return 32'hFFFF_FFFF;
      else return $urandom;
   endfunction

   function automatic logic [3:0] pick_opcode(int mode);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) return 4'(OP_CLEAR + $urandom_range(1, 7));
      if (sel < 5) return OP_CLEAR;
      case (mode)
         0: begin
            if (sel < 40) return OP_PUSH_BACK;
            if (sel < 75) return OP_PUSH_FRONT;
         end
         1: begin
            if (sel < 35) return OP_POP_FRONT;
            if (sel < 65) return OP_POP_BACK;
         end
         default: begin
            if (sel < 20) return OP_SEARCH;
            if (sel < 40) return OP_REMOVE;
         end
      endcase
      return 4'($urandom_range(OP_PUSH_FRONT, OP_TAIL));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
         gap_left = 0;
      end else begin
         if (start && !busy) expected_rsp.push_back(deque_apply(req_item));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (pend_items.size() == 0) begin
               start <= 1'b0;
            end else if (pend_gaps[0] != 0) begin
               gap_left = pend_gaps[0] - 1;
               pend_gaps[0] = 0;
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_item <= pend_items.pop_front();
               void'(pend_gaps.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: result with none expected: value %h found %0d status %0d count %0d",
                     $time, rsp_item.result_value, rsp_item.found, rsp_item.status,
                     rsp_item.count);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item !== want) begin
               $display("%0t: expected value %h found %0d status %0d count %0d, got value %h found %0d status %0d count %0d",
                        $time, want.result_value, want.found, want.status, want.count,
                        rsp_item.result_value, rsp_item.found, rsp_item.status,
                        rsp_item.count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int n;
      int mode;
      int idle_on;
      int gap;
      // directed cases on an empty deque, then on a short deque, unknown opcodes and clear
      queue_item(OP_POP_FRONT, 32'h0, 0);
      queue_item(OP_POP_BACK, 32'h0, 2);
      queue_item(OP_HEAD, 32'h0, 0);
      queue_item(OP_TAIL, 32'h0, 0);
      queue_item(OP_SEARCH, 32'h0, 0);
      queue_item(OP_REMOVE, 32'h0, 0);
      queue_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 0);
      queue_item(OP_PUSH_FRONT, 32'h0, 3);
      queue_item(OP_HEAD, 32'h0, 0);
      queue_item(OP_TAIL, 32'h0, 0);
      queue_item(OP_SEARCH, 32'hFFFF_FFFF, 0);
      queue_item(OP_SEARCH, 32'h5, 0);
      queue_item(OP_REMOVE, 32'h5, 0);
      queue_item(OP_PUSH_BACK, 32'h1, 0);
      queue_item(OP_PUSH_BACK, 32'h2, 1);
      queue_item(OP_REMOVE, 32'h0, 0);
      queue_item(OP_TAIL, 32'h0, 0);
      queue_item(OP_POP_FRONT, 32'h0, 0);
      queue_item(OP_POP_BACK, 32'h0, 0);
      queue_item(OP_CLEAR + 4'd1, 32'hA5A5_5A5A, 0);
      queue_item(OP_CLEAR + 4'd7, 32'h5A5A_A5A5, 0);
      queue_item(OP_CLEAR, 32'h0, 0);
      queue_item(OP_HEAD, 32'h0, 0);

      // random bursts, each biased toward filling, draining or lookups
      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         idle_on = $urandom_range(0, 2);
         repeat ($urandom_range(10, 40)) begin
            gap = 0;
            if (idle_on != 0 && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
               gap = $urandom_range(1, 12);
            queue_item(pick_opcode(mode), pick_value(), gap);
            n++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pend_items.size() != 0 || start) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
